// ===== sv/ppi_pkg.sv =====
// ----------------------------------------------------------------------------
// ppi_pkg
// Constants and the arctangent table for the planar pose integrator.
// ----------------------------------------------------------------------------
package ppi_pkg;

  localparam int AtanEntries = 24;

  // cordic gain 0.60725293500888 in q2.30
  localparam logic [33:0] CordicGain = 34'd652032874;
  // 8/pi in q2.30
  localparam logic [33:0] EightOverPi = 34'd2734261102;

  localparam logic [31:0] QuarterTurn = 32'h4000_0000;
  localparam logic [31:0] HalfTurn    = 32'h8000_0000;

  typedef logic [31:0] angle_t;

  function automatic angle_t atan_lookup(input logic [4:0] idx);
    angle_t r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/planar_pose_integrator.sv =====
// ----------------------------------------------------------------------------
// planar_pose_integrator
// Dead-reckoning odometry: integrates velocity and yaw rate into a planar pose.
//
// in_* carries one tick request (lin_vel, yaw_rate, elapsed). For every
// request the block updates x and y with v*cos/sin of the old heading times
// dt, saturating, then adds omega*dt to the heading, and presents the new
// pose on out_*. Exactly one result per request, in order.
// A request goes through these steps in order: an iterated cordic runs
// alongside the bit-serial v*dt and w*dt multipliers, then cos/sin are loaded
// into the multipliers, then three radix-2 shift-add multipliers run, then
// one rounding step and one update step. in_tready is high only between
// requests, so a new request is taken only after the previous one has been
// committed. The pose registers drive out_tdata directly; a stalled receiver
// holds the result and the next request is computed but not committed until
// the previous result has been taken.
// Reset clears the pose to zero and drops out_tvalid.
// ----------------------------------------------------------------------------
module planar_pose_integrator #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // lin_vel, yaw_rate, elapsed
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata   // pos_x, pos_y, heading
);

  localparam int Steps = (CORDIC_STEPS > ppi_pkg::AtanEntries) ?
                         ppi_pkg::AtanEntries : CORDIC_STEPS;
  localparam int CordCycles = ((Steps > 16) ? Steps : 16) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CORD = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [15:0] v_r, w_r;
  logic [16:0] phi_r, qhi_r;
  logic [15:0] plo_r, qlo_r;

  logic signed [33:0] cx_r, cy_r;
  logic [31:0] cz_r;
  logic        flip_r;

  logic [32:0] mhi_r [3];
  logic [33:0] mlo_r [3];

  logic [28:0] dx_r, dy_r;
  logic [31:0] dth_r;
  logic [31:0] acc_x_r, acc_y_r, acc_h_r;

  logic [16:0] psum, qsum;
  logic signed [33:0] sx, sy;
  logic [31:0] mcand [3];
  logic [32:0] msum [3];
  logic [66:0] prod [3];
  logic [66:0] rnd [3];
  logic [32:0] nx, ny;
  logic [31:0] hsh;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {acc_h_r, acc_y_r, acc_x_r};

  assign psum = phi_r + (plo_r[0] ? {v_r[15], v_r} : 17'd0);
  assign qsum = qhi_r + (qlo_r[0] ? {w_r[15], w_r} : 17'd0);
  assign sx   = cx_r >>> cnt_r[4:0];
  assign sy   = cy_r >>> cnt_r[4:0];

  assign mcand[0] = {phi_r[15:0], plo_r};
  assign mcand[1] = {phi_r[15:0], plo_r};
  assign mcand[2] = {qhi_r[15:0], qlo_r};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!mlo_r[k][0]) begin
        msum[k] = mhi_r[k];
      end else if (cnt_r == 6'd33) begin
        msum[k] = mhi_r[k] - {mcand[k][31], mcand[k]};
      end else begin
        msum[k] = mhi_r[k] + {mcand[k][31], mcand[k]};
      end
      prod[k] = {mhi_r[k], mlo_r[k]};
      rnd[k]  = prod[k] + (67'd1 << 37);
    end
    rnd[2] = prod[2] + (67'd1 << 29);
  end

  assign nx = {acc_x_r[31], acc_x_r} + {{4{dx_r[28]}}, dx_r};
  assign ny = {acc_y_r[31], acc_y_r} + {{4{dy_r[28]}}, dy_r};
  assign hsh = acc_h_r + ppi_pkg::QuarterTurn;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_CORD;
          cnt_nxt   = 6'd0;
        end
      end
      S_CORD: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(CordCycles - 1)) begin
          state_nxt = S_MUL;
          cnt_nxt   = 6'd0;
        end
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd33) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (!out_valid_r || out_tready) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 6'd0;
      out_valid_r <= 1'b0;
      acc_x_r     <= 32'd0;
      acc_y_r     <= 32'd0;
      acc_h_r     <= 32'd0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_UPD && (!out_valid_r || out_tready)) begin
        if (nx[32] != nx[31]) begin
          acc_x_r <= nx[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          acc_x_r <= nx[31:0];
        end
        if (ny[32] != ny[31]) begin
          acc_y_r <= ny[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          acc_y_r <= ny[31:0];
        end
        acc_h_r <= acc_h_r + dth_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        v_r    <= in_tdata[15:0];
        w_r    <= in_tdata[31:16];
        plo_r  <= in_tdata[47:32];
        qlo_r  <= in_tdata[47:32];
        phi_r  <= 17'd0;
        qhi_r  <= 17'd0;
        flip_r <= hsh[31];
        cz_r   <= hsh[31] ? (acc_h_r ^ ppi_pkg::HalfTurn) : acc_h_r;
        cx_r   <= ppi_pkg::CordicGain;
        cy_r   <= 34'sd0;
      end
      S_CORD: begin
        if (cnt_r < 6'd16) begin
          phi_r <= {psum[16], psum[16:1]};
          plo_r <= {psum[0], plo_r[15:1]};
          qhi_r <= {qsum[16], qsum[16:1]};
          qlo_r <= {qsum[0], qlo_r[15:1]};
        end
        if (cnt_r < 6'(Steps)) begin
          if (!cz_r[31]) begin
            cx_r <= cx_r - sy;
            cy_r <= cy_r + sx;
            cz_r <= cz_r - ppi_pkg::atan_lookup(cnt_r[4:0]);
          end else begin
            cx_r <= cx_r + sy;
            cy_r <= cy_r - sx;
            cz_r <= cz_r + ppi_pkg::atan_lookup(cnt_r[4:0]);
          end
        end
        if (cnt_r == 6'(CordCycles - 1)) begin
          mhi_r[0] <= 33'd0;
          mhi_r[1] <= 33'd0;
          mhi_r[2] <= 33'd0;
          mlo_r[0] <= flip_r ? 34'(-cx_r) : cx_r;
          mlo_r[1] <= flip_r ? 34'(-cy_r) : cy_r;
          mlo_r[2] <= ppi_pkg::EightOverPi;
        end
      end
      S_MUL: begin
        for (int k = 0; k < 3; k++) begin
          mhi_r[k] <= {msum[k][32], msum[k][32:1]};
          mlo_r[k] <= {msum[k][0], mlo_r[k][33:1]};
        end
      end
      S_RND: begin
        dx_r  <= rnd[0][66:38];
        dy_r  <= rnd[1][66:38];
        dth_r <= rnd[2][61:30];
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sim/planar_pose_integrator_tb.sv =====
// ----------------------------------------------------------------------------
// planar_pose_integrator_tb
// Self-checking bench for the planar pose integrator. Tick requests go in
// through a directed table and then random ticks; a built-in odometry
// predictor (cordic, rounding, saturation) gives the expected pose for each
// accepted request, and every returned pose is compared field by field.
// ----------------------------------------------------------------------------
module planar_pose_integrator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Steps = 16;

  typedef struct packed {
    logic [15:0] elapsed;
    logic [15:0] yaw_rate;
    logic [15:0] lin_vel;
  } tick_t;

  typedef struct packed {
    logic [31:0] heading;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } pose_t;

  typedef struct {
    tick_t tick;
    logic  has_exp;
    pose_t exp;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;

  planar_pose_integrator #(.CORDIC_STEPS(Steps)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  logic [31:0] odo_x, odo_y, odo_th;
  pose_t       pose_q[$];
  int          err_cnt;
  int          tick_cnt;
  int          pose_cnt;
  int          sat_cnt;
  int          send_idle_pct;
  int          recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(logic [31:0] acc, longint d);
    longint r;
    r = longint'($signed(acc)) + d;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  // advance the odometry state by one tick and return the new pose
  function automatic pose_t odometry_advance(tick_t t);
    logic    flip;
    logic [31:0] a;
    longint  z, cx, sy, dx, dy, c, s, p, q, dth;
    pose_t   r;
    flip = ((odo_th + ppi_pkg::QuarterTurn) & ppi_pkg::HalfTurn) != 0;
    a = flip ? (odo_th ^ ppi_pkg::HalfTurn) : odo_th;
    z = longint'($signed(a));
    cx = longint'(ppi_pkg::CordicGain);
    sy = 0;
    for (int i = 0; i < Steps && i < ppi_pkg::AtanEntries; i++) begin
      dx = floor_shift(sy, i);
      dy = floor_shift(cx, i);
      if (z >= 0) begin
        cx -= dx; sy += dy; z -= longint'(ppi_pkg::atan_lookup(i[4:0]));
      end else begin
        cx += dx; sy -= dy; z += longint'(ppi_pkg::atan_lookup(i[4:0]));
      end
    end
    c = flip ? -cx : cx;
    s = flip ? -sy : sy;
    p = longint'($signed(t.lin_vel)) * longint'(t.elapsed);
    odo_x = 32'(clamp32(odo_x, floor_shift(p * c + (64'sd1 <<< 37), 38)));
    odo_y = 32'(clamp32(odo_y, floor_shift(p * s + (64'sd1 <<< 37), 38)));
    q = longint'($signed(t.yaw_rate)) * longint'(t.elapsed);
    dth = floor_shift(q * longint'(ppi_pkg::EightOverPi) + (64'sd1 <<< 29), 30);
    odo_th = odo_th + 32'(dth);
    r.pos_x = odo_x;
    r.pos_y = odo_y;
    r.heading = odo_th;
    return r;
  endfunction

  task automatic report_error(string msg);
    $display("%s", msg);
    err_cnt++;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    report_error($sformatf("mismatch %s at pose %0d: got %08h want %08h",
                           what, pose_cnt, got, want));
  endtask

  // result side
  always @(posedge clk) begin
    pose_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pose_q.size() == 0) begin
        report_error($sformatf("unexpected pose %024h", out_tdata));
      end else begin
        want = pose_q.pop_front();
        if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
        if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
        if (got.heading !== want.heading)
          report_mismatch("heading", got.heading, want.heading);
      end
      pose_cnt++;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_tick(tick_t t, logic has_exp, pose_t exp);
    pose_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= t;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = odometry_advance(t);
    if (has_exp && p !== exp) begin
      report_error($sformatf("table row disagrees with predictor at tick %0d", tick_cnt));
    end
    if (p.pos_x == 32'h7fffffff || p.pos_x == 32'h80000000 ||
        p.pos_y == 32'h7fffffff || p.pos_y == 32'h80000000) sat_cnt++;
    pose_q.push_back(has_exp ? exp : p);
    tick_cnt++;
    @(negedge clk);
  endtask

  function automatic tick_t rand_tick();
    tick_t t;
    int k;
    k = $urandom_range(9);
    t.lin_vel  = 16'($urandom);
    t.yaw_rate = 16'($urandom);
    t.elapsed  = (k < 6) ? 16'($urandom_range(2000)) : 16'($urandom);
    if (k == 0) t.elapsed = 16'd0;
    if (k == 1) t.lin_vel = $urandom_range(1) ? 16'h7fff : 16'h8000;
    return t;
  endfunction

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pose_q.size() != 0) @(negedge clk);
  endtask

  row_t  dir_tab[$];
  pose_t none;

  function automatic row_t mk(logic [15:0] v, logic [15:0] w, logic [15:0] e,
                              logic h = 1'b0, pose_t x = '0);
    row_t r;
    r.tick = '{elapsed: e, yaw_rate: w, lin_vel: v};
    r.has_exp = h;
    r.exp = x;
    return r;
  endfunction

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    err_cnt = 0; tick_cnt = 0; pose_cnt = 0; sat_cnt = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    none = '0;
    odo_x = '0; odo_y = '0; odo_th = '0;

    // zero ticks after reset, then straight-line and turning ticks up to full speed
    dir_tab.push_back(mk(16'h0000, 16'h0000, 16'h0000, 1'b1, '0));
    dir_tab.push_back(mk(16'h7fff, 16'h7fff, 16'h0000, 1'b1, '0));
    dir_tab.push_back(mk(16'h8000, 16'h8000, 16'h0000, 1'b1, '0));
    dir_tab.push_back(mk(16'h0100, 16'h0000, 16'hffff));
    dir_tab.push_back(mk(16'h7fff, 16'h0000, 16'hffff));
    dir_tab.push_back(mk(16'h8000, 16'h0000, 16'hffff));
    dir_tab.push_back(mk(16'h0000, 16'h7fff, 16'hffff));
    dir_tab.push_back(mk(16'h0100, 16'h0000, 16'h8000));
    dir_tab.push_back(mk(16'h0000, 16'h8000, 16'hffff));
    dir_tab.push_back(mk(16'hffff, 16'hffff, 16'h0001));
    dir_tab.push_back(mk(16'h0001, 16'h0001, 16'h0001));
    dir_tab.push_back(mk(16'h0000, 16'h3244, 16'h8000));
    dir_tab.push_back(mk(16'h0200, 16'h0000, 16'h4000));
    dir_tab.push_back(mk(16'h0000, 16'h3244, 16'hffff));
    dir_tab.push_back(mk(16'haaaa, 16'h5555, 16'haaaa));
    dir_tab.push_back(mk(16'h5555, 16'haaaa, 16'h5555));
    dir_tab.push_back(mk(16'h1234, 16'h0000, 16'h0000));
    // drive x toward positive saturation
    for (int i = 0; i < 6; i++) dir_tab.push_back(mk(16'h7fff, 16'h0000, 16'hffff));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_tick(dir_tab[i].tick, dir_tab[i].has_exp, dir_tab[i].exp);
    wait_drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        3: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
        default: begin send_idle_pct = 48; recv_stall_pct = 48; end
      endcase
      for (int n = 0; n < 120; n++) begin
        send_tick(rand_tick(), 1'b0, none);
        if (n == 60) wait_drain();
      end
    end

    wait_drain();
    repeat (100) @(posedge clk);
    $display("%0d ticks sent, %0d poses checked, %0d at a position limit",
             tick_cnt, pose_cnt, sat_cnt);
    if (err_cnt == 0 && pose_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/ppi_pkg.sv
sv/planar_pose_integrator.sv
sim/planar_pose_integrator_tb.sv
